### rtl/pfa_pkg.sv
// Shared types, constants and codes of the page frame allocator.
package pfa_pkg;

  localparam int unsigned MANAGED_PAGES_DEF = 1024;
  localparam int unsigned WORD_W            = 32;
  localparam int unsigned WORD_SEL_W        = 5;
  localparam int unsigned PAGE_SHIFT        = 12;
  localparam int unsigned PAGE_W            = 20;
  localparam int unsigned ADDR_W            = 32;
  localparam int unsigned STATUS_W          = 3;

  localparam logic [PAGE_W-1:0] LOW_MEM_RESET = 20'd256;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_OUT_OF_MEMORY = 3'd1,
    ST_LOW_MEM       = 3'd2,
    ST_ALREADY_FREE  = 3'd3,
    ST_BEYOND_RANGE  = 3'd4
  } pfa_status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } pfa_cmd_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_SCAN,
    S_FREE_CHK,
    S_FREE_WR,
    S_DONE
  } pfa_state_e;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] free_address;
  } pfa_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   page_address;
    logic [STATUS_W-1:0] status;
  } pfa_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        clr_wr;
    logic        cnt_clr;
    logic        cnt_inc;
    logic        scan_rd;
    logic        alloc_wr;
    logic        free_cap;
    logic        free_rd;
    logic        free_wr;
    logic        res_load;
    pfa_status_e res_status;
    logic        res_addr;
    logic        out_load;
  } pfa_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_last;
    logic chk_last;
    logic hit;
    logic free_low;
    logic free_beyond;
    logic free_bit_set;
  } pfa_sts_t;

endpackage

### rtl/pfa_dp.sv
// Datapath of the page frame allocator: used map memory, scan logic and result registers.
module pfa_dp
  import pfa_pkg::*;
#(
  parameter int unsigned MANAGED_PAGES = MANAGED_PAGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PAGE_W-1:0] cfg_data_i,
  input  pfa_in_t           in_word_i,
  input  pfa_ctl_t          ctl_i,
  output pfa_sts_t          sts_o,
  output pfa_out_t          out_word_o
);

  localparam int unsigned WORDS     = (MANAGED_PAGES + WORD_W - 1) / WORD_W;
  localparam int unsigned WA_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned IDX_W     = WA_W + WORD_SEL_W;
  localparam int unsigned TAIL_BITS = MANAGED_PAGES % WORD_W;
  localparam logic [WORD_W-1:0] TAIL_MASK = (TAIL_BITS == 0) ? {WORD_W{1'b1}} :
                                            WORD_W'((64'd1 << TAIL_BITS) - 64'd1);
  localparam logic [WA_W-1:0]   LAST_WORD = WA_W'(WORDS - 1);
  localparam logic [PAGE_W-1:0] MP_PAGES  = PAGE_W'(MANAGED_PAGES);

  logic [WORD_W-1:0]     mem_q [WORDS];
  logic [WORD_W-1:0]     rdata_q;
  logic [WA_W-1:0]       chk_q;
  logic [WA_W-1:0]       cnt_q;
  logic [PAGE_W-1:0]     low_q;
  logic [PAGE_W-1:0]     page_q;
  logic [IDX_W-1:0]      free_idx_q;
  pfa_out_t              res_q;
  pfa_out_t              out_q;

  logic                  we;
  logic [WA_W-1:0]       waddr;
  logic [WORD_W-1:0]     wdata;
  logic                  re;
  logic [WA_W-1:0]       raddr;
  logic [WORD_W-1:0]     avail;
  logic [WORD_SEL_W-1:0] bit_sel;
  logic [IDX_W-1:0]      alloc_idx;
  logic [PAGE_W-1:0]     alloc_page;
  logic [PAGE_W-1:0]     diff;
  logic [WORD_W-1:0]     free_mask;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q <= LOW_MEM_RESET;
    end else if (cfg_we_i) begin
      low_q <= cfg_data_i;
    end
  end

  // Word counter, used both by the clearing pass and by the scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (ctl_i.cnt_inc) begin
      cnt_q <= cnt_q + WA_W'(1);
    end
  end

  // Lowest free bit of the word under check; padding bits of the last word count as used.
  always_comb begin
    avail   = ~rdata_q & ((chk_q == LAST_WORD) ? TAIL_MASK : {WORD_W{1'b1}});
    bit_sel = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (avail[i]) begin
        bit_sel = WORD_SEL_W'(i);
      end
    end
  end

  assign alloc_idx  = {chk_q, bit_sel};
  assign alloc_page = low_q + PAGE_W'(alloc_idx);
  assign diff       = page_q - low_q;
  assign free_mask  = WORD_W'(1) << free_idx_q[WORD_SEL_W-1:0];

  always_comb begin
    we    = ctl_i.clr_wr | ctl_i.alloc_wr | ctl_i.free_wr;
    waddr = cnt_q;
    wdata = '0;
    if (ctl_i.alloc_wr) begin
      waddr = chk_q;
      wdata = rdata_q | (WORD_W'(1) << bit_sel);
    end else if (ctl_i.free_wr) begin
      waddr = free_idx_q[IDX_W-1:WORD_SEL_W];
      wdata = rdata_q & ~free_mask;
    end
  end

  assign re    = ctl_i.scan_rd | ctl_i.free_rd;
  assign raddr = ctl_i.free_rd ? diff[IDX_W-1:WORD_SEL_W] : cnt_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
      chk_q   <= raddr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.free_cap) begin
      page_q <= in_word_i.free_address[ADDR_W-1:PAGE_SHIFT];
    end
    if (ctl_i.free_rd) begin
      free_idx_q <= diff[IDX_W-1:0];
    end
    if (ctl_i.res_load) begin
      res_q.status       <= ctl_i.res_status;
      res_q.page_address <= ctl_i.res_addr ? {alloc_page, {PAGE_SHIFT{1'b0}}} : '0;
    end
    if (ctl_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign sts_o.cnt_last     = (cnt_q == LAST_WORD);
  assign sts_o.chk_last     = (chk_q == LAST_WORD);
  assign sts_o.hit          = |avail;
  assign sts_o.free_low     = (page_q < low_q);
  assign sts_o.free_beyond  = (diff >= MP_PAGES);
  assign sts_o.free_bit_set = |(rdata_q & free_mask);

  assign out_word_o = out_q;

endmodule

### rtl/pfa_ctrl.sv
// Controller state machine of the page frame allocator.
module pfa_ctrl
  import pfa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_cmd_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  pfa_sts_t sts_i,
  output pfa_ctl_t ctl_o
);

  pfa_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign accept = in_valid_i && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.cnt_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = (pfa_cmd_e'(in_cmd_i) == CMD_FREE) ? S_FREE_CHK : S_ALLOC_RD;
        end
      end
      S_ALLOC_RD: begin
        state_d = S_ALLOC_SCAN;
      end
      S_ALLOC_SCAN: begin
        if (sts_i.hit || sts_i.chk_last) begin
          state_d = S_DONE;
        end
      end
      S_FREE_CHK: begin
        state_d = (sts_i.free_low || sts_i.free_beyond) ? S_DONE : S_FREE_WR;
      end
      S_FREE_WR: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    ctl_o            = '0;
    ctl_o.res_status = ST_OK;
    case (state_q)
      S_CLEAR: begin
        ctl_o.clr_wr  = 1'b1;
        ctl_o.cnt_inc = 1'b1;
        ctl_o.cnt_clr = sts_i.cnt_last;
      end
      S_IDLE: begin
        ctl_o.free_cap = accept;
      end
      S_ALLOC_RD: begin
        ctl_o.scan_rd = 1'b1;
        ctl_o.cnt_inc = 1'b1;
      end
      S_ALLOC_SCAN: begin
        if (sts_i.hit) begin
          ctl_o.alloc_wr   = 1'b1;
          ctl_o.res_load   = 1'b1;
          ctl_o.res_addr   = 1'b1;
          ctl_o.res_status = ST_OK;
          ctl_o.cnt_clr    = 1'b1;
        end else if (sts_i.chk_last) begin
          ctl_o.res_load   = 1'b1;
          ctl_o.res_status = ST_OUT_OF_MEMORY;
          ctl_o.cnt_clr    = 1'b1;
        end else begin
          ctl_o.scan_rd = 1'b1;
          ctl_o.cnt_inc = 1'b1;
        end
      end
      S_FREE_CHK: begin
        if (sts_i.free_low) begin
          ctl_o.res_load   = 1'b1;
          ctl_o.res_status = ST_LOW_MEM;
        end else if (sts_i.free_beyond) begin
          ctl_o.res_load   = 1'b1;
          ctl_o.res_status = ST_BEYOND_RANGE;
        end else begin
          ctl_o.free_rd = 1'b1;
        end
      end
      S_FREE_WR: begin
        ctl_o.res_load   = 1'b1;
        ctl_o.free_wr    = sts_i.free_bit_set;
        ctl_o.res_status = sts_i.free_bit_set ? ST_OK : ST_ALREADY_FREE;
      end
      S_DONE: begin
        ctl_o.out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        ctl_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### rtl/page_frame_allocator_unit.sv
// Top level of the first-fit page frame allocator.
//
// The block keeps one used bit for each managed 4 KiB frame, held in a memory of
// 32-bit words. An input word carries a command: allocate returns the byte address
// of the lowest free frame and marks it used, or reports out of memory; free clears
// the frame at the given byte address, or reports an error for a low-memory,
// already-free or out-of-range frame. Every input word gives exactly one output word.
// Both data channels use valid and stall; a word moves when valid is high and stall
// is low. The configuration channel writes the low-memory page count whenever its
// valid is high, as ready is tied high; it is to be written only while the block
// is idle, which the block itself does not enforce. An allocate reads map words from
// the lowest up until one with a free bit is found (at most 32 words with the default
// 1024 frames); the scan reads one word a cycle through the single read port of the
// map memory. A free checks the range, reads the map word and clears the used bit if
// it is set; a frame refused as low-memory or out-of-range skips the read.
// The output register lets the next input word be accepted while a result waits.
// After reset the map is cleared in a pass of one word a cycle, during which input
// stall stays high.
// When the receiver stalls, a finished result is held in the output register; a
// further result waits inside the block until that register is free.
module page_frame_allocator_unit
  import pfa_pkg::*;
#(
  parameter int unsigned MANAGED_PAGES = MANAGED_PAGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [PAGE_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pfa_in_t           in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pfa_out_t          out_word_o
);

  pfa_ctl_t ctl;
  pfa_sts_t sts;

  // The register is always ready to take a write.
  assign cfg_ready_o = 1'b1;

  pfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_word_i.cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  pfa_dp #(
    .MANAGED_PAGES (MANAGED_PAGES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (in_word_i),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule
